/* rtl/rhc_pkg.sv */
// Shared constants, types and the reciprocal table of the RGB/HSV color converter.
`default_nettype none

package rhc_pkg;

    // Field widths.
    localparam int CH_W  = 8;
    localparam int HUE_W = 11;
    localparam int NUM_W = 16;
    localparam int REC_W = 18;

    // Pipeline depth: two front stages, three divider stages, one output stage.
    localparam int NUM_STAGES = 6;

    // Direction register codes.
    localparam logic DIR_RGB2HSV = 1'b0;
    localparam logic DIR_HSV2RGB = 1'b1;

    // Largest legal hue and the 255*256 full scale of the hexcone products.
    localparam logic [HUE_W-1:0] HUE_MAX    = 11'd1536;
    localparam logic [NUM_W-1:0] FULL_SCALE = 16'd65280;
    localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;

    // Hexcone sectors that need their own channel routing.
    localparam logic [2:0] SEC_YG = 3'd1;  // yellow to green
    localparam logic [2:0] SEC_GC = 3'd2;  // green to cyan
    localparam logic [2:0] SEC_CB = 3'd3;  // cyan to blue
    localparam logic [2:0] SEC_BM = 3'd4;  // blue to magenta
    localparam logic [2:0] SEC_MR = 3'd5;  // magenta to red

    // Per-item side information that travels beside the divider.
    typedef struct packed {
        logic            dir;
        logic            flat;    // equal channels, or hue zero
        logic [2:0]      sector;
        logic            neg;     // hue fraction is added instead of subtracted
        logic [CH_W-1:0] val;
    } t_side;

    // Two division requests, numerator over divisor.
    typedef struct packed {
        logic [NUM_W-1:0] na;
        logic [CH_W-1:0]  da;
        logic [NUM_W-1:0] nb;
        logic [CH_W-1:0]  db;
    } t_div_req;

    // Final result fields.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_result;

    // Shift-subtract long division of 2^17 by d, used only to build the table.
    function automatic logic [REC_W-1:0] recip_calc(input logic [CH_W-1:0] d);
        logic [REC_W-1:0] num;
        logic [REC_W-1:0] quo;
        logic [CH_W+1:0]  rem;
        num = {1'b1, {(REC_W-1){1'b0}}};
        quo = '0;
        rem = '0;
        for (int i = REC_W - 1; i >= 0; i--) begin
            rem = {rem[CH_W:0], num[i]};
            if (rem >= {2'b00, d}) begin
                rem    = rem - {2'b00, d};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table of floor(2^17 / d); a zero divisor reads as one.
    function automatic logic [255:0][REC_W-1:0] build_recip();
        logic [255:0][REC_W-1:0] tab;
        tab[0] = recip_calc(8'd1);
        for (int i = 1; i < 256; i++) begin
            tab[i] = recip_calc(8'(i));
        end
        return tab;
    endfunction

    localparam logic [255:0][REC_W-1:0] RECIP_TAB = build_recip();

endpackage

`default_nettype wire

/* rtl/rhc_cfg_if.sv */
// Configuration write channel carrying the direction register.
`default_nettype none

interface rhc_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

`default_nettype wire

/* rtl/rhc_in_if.sv */
// Input request channel with the RGB and HSV input fields.
`default_nettype none

interface rhc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [10:0] hue_in;
    logic [7:0]  sat_in;
    logic [7:0]  val_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output hue_in, output sat_in, output val_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input hue_in, input sat_in, input val_in, output ready);
endinterface

`default_nettype wire

/* rtl/rhc_out_if.sv */
// Output request channel with the HSV and RGB result fields.
`default_nettype none

interface rhc_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] hue_out;
    logic [7:0]  sat_out;
    logic [7:0]  val_out;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    modport source (output valid, output hue_out, output sat_out, output val_out,
                    output red_out, output green_out, output blue_out, input ready);
    modport sink   (input valid, input hue_out, input sat_out, input val_out,
                    input red_out, input green_out, input blue_out, output ready);
endinterface

`default_nettype wire

/* rtl/rhc_front.sv */
// Front end: classifies the input and forms the two division requests (two stages).
`default_nettype none

module rhc_front (
    input  wire logic                   i_clk,
    input  wire logic [1:0]             i_en,
    input  wire logic                   i_dir,
    input  wire logic [7:0]             i_red,
    input  wire logic [7:0]             i_green,
    input  wire logic [7:0]             i_blue,
    input  wire logic [10:0]            i_hue,
    input  wire logic [7:0]             i_sat,
    input  wire logic [7:0]             i_val,
    output rhc_pkg::t_side              o_side,
    output rhc_pkg::t_div_req           o_req
);
    import rhc_pkg::*;

    // RGB side signals.
    logic [CH_W-1:0]  lo, hi, lo_rg, hi_rg, mag, diff;
    logic [2:0]       rgb_sector;
    logic             rgb_neg;
    // HSV side signals.
    logic [HUE_W-1:0] hue_cl;
    logic [2:0]       hsv_sector;
    logic [CH_W:0]    frac;
    logic [CH_W:0]    frac_m;
    logic [16:0]      sf;
    logic [NUM_W-1:0] term;
    logic [CH_W-1:0]  sat_inv;
    logic [NUM_W-1:0] ya;

    t_side            n_side1;
    logic [NUM_W-1:0] n_na1, n_x1;
    logic [CH_W-1:0]  n_da1, n_db1;

    t_side            r_side1, r_side2;
    logic [NUM_W-1:0] r_na1, r_x1;
    logic [CH_W-1:0]  r_da1, r_db1;
    t_div_req         r_req2;
    t_div_req         n_req2;
    logic [23:0]      vterm;

    // Minimum, maximum and the sector chosen by the minimum channel.
    always_comb begin
        lo_rg = (i_red < i_green) ? i_red : i_green;
        hi_rg = (i_red > i_green) ? i_red : i_green;
        lo    = (i_blue < lo_rg) ? i_blue : lo_rg;
        hi    = (i_blue > hi_rg) ? i_blue : hi_rg;
        diff  = hi - lo;
        priority if (i_red == lo) begin
            rgb_sector = SEC_CB;
            rgb_neg    = i_green < i_blue;
            mag        = rgb_neg ? (i_blue - i_green) : (i_green - i_blue);
        end else if (i_green == lo) begin
            rgb_sector = SEC_MR;
            rgb_neg    = i_blue < i_red;
            mag        = rgb_neg ? (i_red - i_blue) : (i_blue - i_red);
        end else begin
            rgb_sector = SEC_YG;
            rgb_neg    = i_red < i_green;
            mag        = rgb_neg ? (i_green - i_red) : (i_red - i_green);
        end
    end

    // Hue clamp, sector, mirrored fraction and the scaled products.
    always_comb begin
        hue_cl     = (i_hue > HUE_MAX) ? HUE_MAX : i_hue;
        hsv_sector = hue_cl[HUE_W-1:8];
        frac       = {1'b0, hue_cl[7:0]};
        frac_m     = hsv_sector[0] ? frac : (9'd256 - frac);
        sf         = 17'(i_sat) * 17'(frac_m);
        term       = 16'(17'(FULL_SCALE) - sf);
        sat_inv    = ~i_sat;
        ya         = 16'(i_val) * 16'(sat_inv);
    end

    // Stage one request selection.
    always_comb begin
        n_side1.dir = i_dir;
        if (i_dir == DIR_HSV2RGB) begin
            n_side1.flat   = (i_hue == '0);
            n_side1.sector = hsv_sector;
            n_side1.neg    = 1'b0;
            n_side1.val    = i_val;
            n_na1          = ya;
            n_da1          = CH_MAX;
            n_x1           = term;
            n_db1          = CH_MAX;
        end else begin
            n_side1.flat   = (hi == lo);
            n_side1.sector = rgb_sector;
            n_side1.neg    = rgb_neg;
            n_side1.val    = hi;
            n_na1          = {mag, 8'b0};
            n_da1          = diff;
            n_x1           = 16'(diff);
            n_db1          = hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_side1 <= n_side1;
            r_na1   <= n_na1;
            r_da1   <= n_da1;
            r_x1    <= n_x1;
            r_db1   <= n_db1;
        end
    end

    // Stage two: second numerator, the saturation product or the n product over 256.
    always_comb begin
        vterm     = 24'(r_side1.val) * 24'(r_x1);
        n_req2.na = r_na1;
        n_req2.da = r_da1;
        n_req2.db = r_db1;
        if (r_side1.dir == DIR_HSV2RGB) begin
            n_req2.nb = vterm[23:8];
        end else begin
            n_req2.nb = {r_x1[7:0], 8'b0} - r_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_side2 <= r_side1;
            r_req2  <= n_req2;
        end
    end

    assign o_side = r_side2;
    assign o_req  = r_req2;

endmodule

`default_nettype wire

/* rtl/rhc_div.sv */
// Two-lane pipelined divider: reciprocal lookup, multiply, one-step correction.
`default_nettype none

module rhc_div (
    input  wire logic                   i_clk,
    input  wire logic [2:0]             i_en,
    input  wire rhc_pkg::t_side         i_side,
    input  wire rhc_pkg::t_div_req      i_req,
    output rhc_pkg::t_side              o_side,
    output logic [rhc_pkg::NUM_W-1:0]   o_qa,
    output logic [rhc_pkg::NUM_W-1:0]   o_qb
);
    import rhc_pkg::*;

    t_side            r_side3, r_side4, r_side5;
    t_div_req         r_req3, r_req4;
    logic [REC_W-1:0] r_ra, r_rb;
    logic [NUM_W-1:0] r_qe_a, r_qe_b;
    logic [NUM_W-1:0] r_qa, r_qb;

    logic [33:0]      prod_a, prod_b;
    logic [23:0]      back_a, back_b, rem_a, rem_b;
    logic [NUM_W-1:0] n_qa, n_qb;

    // Stage three: reciprocal of each divisor from the constant table.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_side3 <= i_side;
            r_req3  <= i_req;
            r_ra    <= RECIP_TAB[i_req.da];
            r_rb    <= RECIP_TAB[i_req.db];
        end
    end

    // Stage four: quotient estimate, exact or one short.
    always_comb begin
        prod_a = 34'(r_req3.na) * 34'(r_ra);
        prod_b = 34'(r_req3.nb) * 34'(r_rb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_side4 <= r_side3;
            r_req4  <= r_req3;
            r_qe_a  <= prod_a[32:17];
            r_qe_b  <= prod_b[32:17];
        end
    end

    // Stage five: remainder check and correction.
    always_comb begin
        back_a = 24'(r_qe_a) * 24'(r_req4.da);
        back_b = 24'(r_qe_b) * 24'(r_req4.db);
        rem_a  = 24'(r_req4.na) - back_a;
        rem_b  = 24'(r_req4.nb) - back_b;
        n_qa   = r_qe_a + 16'(rem_a >= 24'(r_req4.da));
        n_qb   = r_qe_b + 16'(rem_b >= 24'(r_req4.db));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_side5 <= r_side4;
            r_qa    <= n_qa;
            r_qb    <= n_qb;
        end
    end

    assign o_side = r_side5;
    assign o_qa   = r_qa;
    assign o_qb   = r_qb;

endmodule

`default_nettype wire

/* rtl/rhc_back.sv */
// Output stage: builds hue and saturation, or routes m, n and value to the channels.
`default_nettype none

module rhc_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire rhc_pkg::t_side         i_side,
    input  wire logic [rhc_pkg::NUM_W-1:0] i_qa,
    input  wire logic [rhc_pkg::NUM_W-1:0] i_qb,
    output rhc_pkg::t_result            o_result
);
    import rhc_pkg::*;

    t_result          n_result, r_result;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] qh;
    logic [CH_W-1:0]  m, n, v;

    always_comb begin
        base     = {i_side.sector, 8'b0};
        qh       = i_qa[HUE_W-1:0];
        m        = i_qa[CH_W-1:0];
        n        = i_qb[CH_W-1:0];
        v        = i_side.val;
        n_result = '0;
        if (i_side.dir == DIR_RGB2HSV) begin
            // Hue and saturation; both are zero for equal channels.
            n_result.val = v;
            if (!i_side.flat) begin
                n_result.hue = i_side.neg ? (base + qh) : (base - qh);
                n_result.sat = i_qb[CH_W-1:0];
            end
        end else if (i_side.flat) begin
            // Hue zero gives grey.
            n_result.red   = v;
            n_result.green = v;
            n_result.blue  = v;
        end else begin
            // Channel routing by sector; sectors zero and six share an arm.
            unique case (i_side.sector)
                SEC_YG: begin
                    n_result.red = n; n_result.green = v; n_result.blue = m;
                end
                SEC_GC: begin
                    n_result.red = m; n_result.green = v; n_result.blue = n;
                end
                SEC_CB: begin
                    n_result.red = m; n_result.green = n; n_result.blue = v;
                end
                SEC_BM: begin
                    n_result.red = n; n_result.green = m; n_result.blue = v;
                end
                SEC_MR: begin
                    n_result.red = v; n_result.green = m; n_result.blue = n;
                end
                default: begin
                    n_result.red = v; n_result.green = n; n_result.blue = m;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/rgb_hsv_color_converter.sv */
// Top level of the hexcone RGB/HSV color converter.
//
// Channels: i_cfg writes the one-bit direction register (0 converts RGB to HSV,
// 1 converts HSV to RGB); it is always ready. The user must ensure that it is
// written only while the converter holds no request; the block does not
// enforce this. i_pix takes one input request per accepted valid/ready cycle;
// o_pix delivers one result per request, in order, with the unused result
// fields of the current direction driven to zero. Each request passes through
// six register stages: two front-end stages, three stages of the reciprocal
// divider (table lookup, estimate multiply, correction) and the output register.
// Throughput: one request per cycle while o_pix.ready is high.
// Stall: each stage holds its request while the next stage is full and stalled,
// so empty stages keep filling and i_pix.ready drops only once all six stages
// hold a request. Nothing is dropped or repeated.
// Reset: i_rst_n, synchronous and active low, empties the pipeline and sets the
// direction to RGB to HSV.
`default_nettype none

module rgb_hsv_color_converter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rhc_cfg_if.sink    i_cfg,
    rhc_in_if.sink     i_pix,
    rhc_out_if.source  o_pix
);
    import rhc_pkg::*;

    logic                  r_direction;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_rdy;
    logic [NUM_STAGES-1:0] stage_in_vld;
    logic [NUM_STAGES-1:0] stage_en;

    t_side            front_side, div_side;
    t_div_req         front_req;
    logic [NUM_W-1:0] qa, qb;
    t_result          result;

    // Direction register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_RGB2HSV;
        end else if (i_cfg.valid) begin
            r_direction <= i_cfg.direction;
        end
    end

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        stage_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_pix.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
        stage_in_vld[0] = i_pix.valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            stage_in_vld[k] = r_vld[k-1];
        end
        stage_en = stage_rdy & stage_in_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= stage_in_vld[k];
                end
            end
        end
    end

    assign i_pix.ready = stage_rdy[0];

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_en    (stage_en[1:0]),
        .i_dir   (r_direction),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .i_hue   (i_pix.hue_in),
        .i_sat   (i_pix.sat_in),
        .i_val   (i_pix.val_in),
        .o_side  (front_side),
        .o_req   (front_req)
    );

    rhc_div u_div (
        .i_clk  (i_clk),
        .i_en   (stage_en[4:2]),
        .i_side (front_side),
        .i_req  (front_req),
        .o_side (div_side),
        .o_qa   (qa),
        .o_qb   (qb)
    );

    rhc_back u_back (
        .i_clk    (i_clk),
        .i_en     (stage_en[5]),
        .i_side   (div_side),
        .i_qa     (qa),
        .i_qb     (qb),
        .o_result (result)
    );

    // Output channel.
    assign o_pix.valid     = r_vld[NUM_STAGES-1];
    assign o_pix.hue_out   = result.hue;
    assign o_pix.sat_out   = result.sat;
    assign o_pix.val_out   = result.val;
    assign o_pix.red_out   = result.red;
    assign o_pix.green_out = result.green;
    assign o_pix.blue_out  = result.blue;

endmodule

`default_nettype wire

/* tb/rgb_hsv_color_converter_tb.sv */
// Self-checking testbench for the hexcone RGB/HSV color converter in both directions.
`default_nettype none

module rgb_hsv_color_converter_tb;
    import rhc_pkg::*;

    // One input request as the testbench builds it.
    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } t_pixel;

    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int CHUNK_PIXELS = 200;

    logic i_clk;
    logic i_rst_n;

    rhc_cfg_if cfg_bus ();
    rhc_in_if  pix_in ();
    rhc_out_if pix_out ();

    // Direction the converter holds, tracked at each accepted register write.
    logic    cur_direction;
    t_result pending_pixels[$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    int      send_idle_pct;
    int      ready_idle_pct;

    rgb_hsv_color_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected result of one conversion under the given direction.
    function automatic t_result hexcone_convert(input logic dir, input t_pixel p);
        t_result     res;
        int unsigned r, g, b, lo, hi, span, mag, frac, sector, hue, m, n;
        bit          neg;
        res = '0;
        if (dir == DIR_RGB2HSV) begin
            r  = p.red;
            g  = p.green;
            b  = p.blue;
            lo = (r < g) ? r : g;
            hi = (r > g) ? r : g;
            if (b < lo) lo = b;
            if (b > hi) hi = b;
            res.val = CH_W'(hi);
            // Equal channels leave hue undefined and saturation zero.
            if (hi != lo) begin
                span = hi - lo;
                // The minimum channel picks the sector; red wins a tie, then green.
                if (r == lo) begin
                    sector = 3;
                    neg    = (g < b);
                    mag    = neg ? b - g : g - b;
                end else if (g == lo) begin
                    sector = 5;
                    neg    = (b < r);
                    mag    = neg ? r - b : b - r;
                end else begin
                    sector = 1;
                    neg    = (r < g);
                    mag    = neg ? g - r : r - g;
                end
                frac    = (mag * 256) / span;
                hue     = neg ? sector * 256 + frac : sector * 256 - frac;
                res.hue = HUE_W'(hue);
                res.sat = CH_W'((span * CH_MAX) / hi);
            end
        end else begin
            if (p.hue == 0) begin
                // Undefined hue is plain grey at the given value.
                res.red   = p.val;
                res.green = p.val;
                res.blue  = p.val;
            end else begin
                hue    = (p.hue > HUE_MAX) ? HUE_MAX : p.hue;
                sector = hue >> 8;
                frac   = hue & 255;
                if (sector % 2 == 0) frac = 256 - frac;
                m = (p.val * (CH_MAX - p.sat)) / CH_MAX;
                n = (p.val * (FULL_SCALE - p.sat * frac)) / FULL_SCALE;
                case (sector)
                    SEC_YG:  res = '{hue: '0, sat: '0, val: '0,
                                     red: CH_W'(n), green: p.val, blue: CH_W'(m)};
                    SEC_GC:  res = '{hue: '0, sat: '0, val: '0,
                                     red: CH_W'(m), green: p.val, blue: CH_W'(n)};
                    SEC_CB:  res = '{hue: '0, sat: '0, val: '0,
                                     red: CH_W'(m), green: CH_W'(n), blue: p.val};
                    SEC_BM:  res = '{hue: '0, sat: '0, val: '0,
                                     red: CH_W'(n), green: CH_W'(m), blue: p.val};
                    SEC_MR:  res = '{hue: '0, sat: '0, val: '0,
                                     red: p.val, green: CH_W'(m), blue: CH_W'(n)};
                    // Sectors zero and six both start at red.
                    default: res = '{hue: '0, sat: '0, val: '0,
                                     red: p.val, green: CH_W'(n), blue: CH_W'(m)};
                endcase
            end
        end
        return res;
    endfunction

    // Send one request, with random idle cycles ahead of it.
    task automatic send_pixel(input t_pixel p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= p.red;
        pix_in.green_in <= p.green;
        pix_in.blue_in  <= p.blue;
        pix_in.hue_in   <= p.hue;
        pix_in.sat_in   <= p.sat;
        pix_in.val_in   <= p.val;
        do begin
            @(posedge i_clk);
        end while (!pix_in.ready);
        pending_pixels.push_back(hexcone_convert(cur_direction, p));
    endtask

    // RGB request; the HSV fields carry random values the converter must ignore.
    task automatic send_rgb(input int r, input int g, input int b);
        t_pixel p;
        p.red   = CH_W'(r);
        p.green = CH_W'(g);
        p.blue  = CH_W'(b);
        p.hue   = HUE_W'($urandom);
        p.sat   = CH_W'($urandom);
        p.val   = CH_W'($urandom);
        send_pixel(p);
    endtask

    // HSV request; the RGB fields carry random values the converter must ignore.
    task automatic send_hsv(input int h, input int s, input int v);
        t_pixel p;
        p.red   = CH_W'($urandom);
        p.green = CH_W'($urandom);
        p.blue  = CH_W'($urandom);
        p.hue   = HUE_W'(h);
        p.sat   = CH_W'(s);
        p.val   = CH_W'(v);
        send_pixel(p);
    endtask

    // Stop sending and wait until every outstanding request has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Write the direction register once the pipeline is empty.
    task automatic write_direction(input logic dir);
        wait_idle();
        @(negedge i_clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.direction <= dir;
        do begin
            @(posedge i_clk);
        end while (!cfg_bus.ready);
        cur_direction = dir;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Primaries, secondaries, grey levels, ties for the minimum and the smallest spread.
    task automatic test_rgb_to_hsv_corners();
        write_direction(DIR_RGB2HSV);
        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(10, 10, 200);
        send_rgb(200, 10, 10);
        send_rgb(1, 0, 0);
    endtask

    // Grey, most sector edges, the top hue and hues above it that saturate.
    task automatic test_hsv_to_rgb_corners();
        write_direction(DIR_HSV2RGB);
        send_hsv(0, 77, 200);
        send_hsv(1, 255, 255);
        send_hsv(255, 255, 255);
        send_hsv(256, 200, 255);
        send_hsv(511, 128, 255);
        send_hsv(768, 255, 100);
        send_hsv(1024, 255, 255);
        send_hsv(1280, 1, 255);
        send_hsv(1535, 255, 255);
        send_hsv(1536, 255, 255);
        send_hsv(1537, 128, 77);
        send_hsv(2047, 255, 255);
        send_hsv(900, 0, 0);
    endtask

    // Random requests in chunks of alternating direction under one idling mix.
    task automatic test_random_stream(input int send_pct, input int ready_pct,
                                      input logic first_dir);
        int   r, g, b, h, s, v;
        logic dir;
        send_idle_pct  = send_pct;
        ready_idle_pct = ready_pct;
        for (int chunk = 0; chunk < 3; chunk++) begin
            dir = first_dir ^ chunk[0];
            write_direction(dir);
            repeat (CHUNK_PIXELS) begin
                if (dir == DIR_RGB2HSV) begin
                    r = $urandom_range(255);
                    g = $urandom_range(255);
                    b = $urandom_range(255);
                    case ($urandom_range(9))
                        0: begin
                            g = r;
                            b = r;
                        end
                        1: begin
                            case ($urandom_range(2))
                                0:       g = r;
                                1:       b = r;
                                default: b = g;
                            endcase
                        end
                        2: begin
                            if ($urandom_range(2) != 0) r = $urandom_range(1) ? 255 : 0;
                            if ($urandom_range(2) != 0) g = $urandom_range(1) ? 255 : 0;
                            if ($urandom_range(2) != 0) b = $urandom_range(1) ? 255 : 0;
                        end
                        default: ;
                    endcase
                    send_rgb(r, g, b);
                end else begin
                    h = $urandom_range(1, HUE_MAX);
                    s = $urandom_range(255);
                    v = $urandom_range(255);
                    case ($urandom_range(9))
                        0: h = 0;
                        1: h = $urandom_range(HUE_MAX + 1, 2047);
                        2: h = $urandom_range(1, 6) * 256 - 1 + $urandom_range(2);
                        3: begin
                            s = $urandom_range(1) ? 255 : 0;
                            v = $urandom_range(1) ? 255 : 0;
                        end
                        default: ;
                    endcase
                    send_hsv(h, s, v);
                end
            end
        end
    endtask

    // Result side: random backpressure, changed at the falling edge.
    always @(negedge i_clk) begin
        pix_out.ready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // Compare each returned request with the oldest expected one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: hue %0d sat %0d val %0d rgb %0d %0d %0d",
                             pix_out.hue_out, pix_out.sat_out, pix_out.val_out,
                             pix_out.red_out, pix_out.green_out, pix_out.blue_out);
            end else begin
                want = pending_pixels.pop_front();
                if (pix_out.hue_out !== want.hue || pix_out.sat_out !== want.sat ||
                    pix_out.val_out !== want.val || pix_out.red_out !== want.red ||
                    pix_out.green_out !== want.green || pix_out.blue_out !== want.blue) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected hsv %0d %0d %0d rgb %0d %0d %0d, %s",
                                 want.hue, want.sat, want.val,
                                 want.red, want.green, want.blue,
                                 $sformatf("got hsv %0d %0d %0d rgb %0d %0d %0d",
                                           pix_out.hue_out, pix_out.sat_out,
                                           pix_out.val_out, pix_out.red_out,
                                           pix_out.green_out, pix_out.blue_out));
                end
            end
        end
    end

    // Watchdog: end the run when no channel has moved for too long.
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("rgb_hsv_color_converter_tb: FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n           = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.direction = DIR_RGB2HSV;
        pix_in.valid      = 1'b0;
        pix_in.red_in     = '0;
        pix_in.green_in   = '0;
        pix_in.blue_in    = '0;
        pix_in.hue_in     = '0;
        pix_in.sat_in     = '0;
        pix_in.val_in     = '0;
        cur_direction     = DIR_RGB2HSV;
        send_idle_pct     = 29;
        ready_idle_pct    = 66;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_rgb_to_hsv_corners();
        test_hsv_to_rgb_corners();
        test_random_stream(29, 66, DIR_HSV2RGB);
        test_random_stream(66, 29, DIR_RGB2HSV);
        test_random_stream(0, 0, DIR_HSV2RGB);

        // Drain, then keep waiting so that any stray result can show up.
        wait_idle();
        repeat (NUM_STAGES + 4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("rgb_hsv_color_converter_tb: PASS");
        else
            $display("rgb_hsv_color_converter_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
